// ===== design/ahpp_pkg.sv =====
package ahpp_pkg;

  localparam int DataW = 32;
  localparam int CfgIdxW = 3;

  // Reset values of the configuration registers
  localparam logic signed [31:0] GainPRst     = 32'sd983;
  localparam logic signed [31:0] GainIRst     = 32'sd197;
  localparam logic signed [31:0] GainDRst     = 32'sd0;
  localparam logic        [16:0] HalfPerRst   = 17'd328;
  localparam logic signed [17:0] DerivPoleRst = 18'sd65405;
  localparam logic        [30:0] DerivGainRst = 31'd1310;
  localparam logic        [30:0] PitchLimRst  = 31'd22877;
  localparam logic        [30:0] ZoneWidthRst = 31'd655360;

  // 0.01 m zone margin and 0.0001 rad hold threshold, in LSB
  localparam logic signed [33:0] ZoneMargin = 34'sd655;
  localparam logic signed [34:0] HoldEpsM1  = 35'sd6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_HALF_PERIOD = 3'd3,
    CFG_DERIV_POLE  = 3'd4,
    CFG_DERIV_GAIN  = 3'd5,
    CFG_PITCH_LIMIT = 3'd6,
    CFG_ZONE_WIDTH  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic        [16:0] half_period;
    logic signed [17:0] deriv_pole;
    logic        [30:0] deriv_gain;
    logic        [30:0] pitch_limit;
    logic        [30:0] zone_width;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_INT,
    MS_POLE,
    MS_DGAIN,
    MS_P,
    MS_I,
    MS_D
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     calc_err;
    logic     calc_zone;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     int_upd;
    logic     acc_load;
    logic     deriv_upd;
    logic     sum_load;
    logic     sum_add;
    logic     finish;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ZONE,
    ST_MUL_INT,
    ST_MUL_POLE,
    ST_MUL_DGAIN,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM_I,
    ST_SUM_D,
    ST_FIN
  } st_t;

endpackage

// ===== design/altitude_hold_pitch_pid_core.sv =====
// Channel   Handshake               Payload
// input     in_valid / in_ready     altitude_command, altitude_measured, restart
// output    out_valid / out_ready   pitch_command, clamped
// config    cfg_write               cfg_index, cfg_data
//
// The result enters the output register from the last state; an item occupies
// the sequencer from its input transfer until then. One shared 34x34 multiplier
// issues six products back to back, each rounded in the following cycle.
// A new input is taken as soon as the sequencer is back in idle, even while
// the previous result waits in the output register; the last state waits only
// while that register is full and not being taken.
// Synchronous reset restores the register defaults and clears the loop state.
module altitude_hold_pitch_pid_core
  import ahpp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DataW-1:0] altitude_command,
  input  logic signed [DataW-1:0] altitude_measured,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] pitch_command,
  output logic                    clamped,
  input  logic                    cfg_write,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [DataW-1:0]        cfg_data
);

  cfg_t cfg;
  cmd_t cmd;

  ahpp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ahpp_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .altitude_command  (altitude_command),
    .altitude_measured (altitude_measured),
    .restart           (restart),
    .pitch_command     (pitch_command),
    .clamped           (clamped)
  );

  logic signed [DataW-1:0] lim32;
  assign lim32 = {1'b0, cfg.pitch_limit};

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> (pitch_command == lim32 || pitch_command == -lim32))
    else $error("clamped result not at the pitch limit");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished item");

endmodule

// ===== design/ahpp_cfg.sv =====
module ahpp_cfg
  import ahpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= GainPRst;
      cfg.gain_i      <= GainIRst;
      cfg.gain_d      <= GainDRst;
      cfg.half_period <= HalfPerRst;
      cfg.deriv_pole  <= DerivPoleRst;
      cfg.deriv_gain  <= DerivGainRst;
      cfg.pitch_limit <= PitchLimRst;
      cfg.zone_width  <= ZoneWidthRst;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:      cfg.gain_p      <= $signed(cfg_data);
        CFG_GAIN_I:      cfg.gain_i      <= $signed(cfg_data);
        CFG_GAIN_D:      cfg.gain_d      <= $signed(cfg_data);
        CFG_HALF_PERIOD: cfg.half_period <= cfg_data[16:0];
        CFG_DERIV_POLE:  cfg.deriv_pole  <= $signed(cfg_data[17:0]);
        CFG_DERIV_GAIN:  cfg.deriv_gain  <= cfg_data[30:0];
        CFG_PITCH_LIMIT: cfg.pitch_limit <= cfg_data[30:0];
        CFG_ZONE_WIDTH:  cfg.zone_width  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ahpp_ctrl.sv =====
module ahpp_ctrl
  import ahpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  st_t  state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_ERR;
      ST_ERR:       state_next = ST_ZONE;
      ST_ZONE:      state_next = ST_MUL_INT;
      ST_MUL_INT:   state_next = ST_MUL_POLE;
      ST_MUL_POLE:  state_next = ST_MUL_DGAIN;
      ST_MUL_DGAIN: state_next = ST_MUL_P;
      ST_MUL_P:     state_next = ST_MUL_I;
      ST_MUL_I:     state_next = ST_MUL_D;
      ST_MUL_D:     state_next = ST_SUM_I;
      ST_SUM_I:     state_next = ST_SUM_D;
      ST_SUM_D:     state_next = ST_FIN;
      ST_FIN:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Each multiply product is registered in prod_q, then rounded into q for the state that uses it
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MS_INT;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ERR:  cmd.calc_err = 1'b1;
      ST_ZONE: cmd.calc_zone = 1'b1;
      ST_MUL_INT: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_INT;
      end
      ST_MUL_POLE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_POLE;
      end
      ST_MUL_DGAIN: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_DGAIN;
        cmd.int_upd = 1'b1;
      end
      ST_MUL_P: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_P;
        cmd.acc_load = 1'b1;
      end
      ST_MUL_I: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_I;
        cmd.deriv_upd = 1'b1;
      end
      ST_MUL_D: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_D;
        cmd.sum_load = 1'b1;
      end
      ST_SUM_I: cmd.sum_add = 1'b1;
      ST_SUM_D: cmd.sum_add = 1'b1;
      ST_FIN:   cmd.finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/ahpp_dp.sv =====
module ahpp_dp
  import ahpp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  input  logic signed [DataW-1:0] altitude_command,
  input  logic signed [DataW-1:0] altitude_measured,
  input  logic                    restart,
  output logic signed [DataW-1:0] pitch_command,
  output logic                    clamped
);

  function automatic logic signed [31:0] sat_33(input logic signed [32:0] x);
    if (x > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -33'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  logic signed [31:0] cmd_q, meas_q;
  logic signed [31:0] err, last_error, integrator, prev_int, derivative, acc;
  logic signed [32:0] dsum, ddif;
  logic               in_zone;
  logic signed [63:0] prod_q;
  logic signed [31:0] q;
  logic signed [33:0] sum;

  logic signed [32:0] diff, zw33;
  logic signed [33:0] zw34, zone_lo, zone_hi, err34;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [63:0] rnd;
  logic signed [47:0] shf;
  logic signed [31:0] rnd_sat;
  logic signed [33:0] lim, pitch;
  logic signed [34:0] sum35, lim35;
  logic               held;

  assign diff = {cmd_q[31], cmd_q} - {meas_q[31], meas_q};
  assign zw33 = {2'b00, cfg.zone_width};
  assign zw34 = {3'b000, cfg.zone_width};
  assign err34 = {{2{err[31]}}, err};
  assign zone_lo = ZoneMargin - zw34;
  assign zone_hi = zw34 - ZoneMargin;

  always_comb begin
    case (cmd.mul_sel)
      MS_INT: begin
        mul_a = {17'd0, cfg.half_period};
        mul_b = {dsum[32], dsum};
      end
      MS_POLE: begin
        mul_a = {{16{cfg.deriv_pole[17]}}, cfg.deriv_pole};
        mul_b = {{2{derivative[31]}}, derivative};
      end
      MS_DGAIN: begin
        mul_a = {3'b000, cfg.deriv_gain};
        mul_b = {ddif[32], ddif};
      end
      MS_P: begin
        mul_a = {{2{cfg.gain_p[31]}}, cfg.gain_p};
        mul_b = err34;
      end
      MS_I: begin
        mul_a = {{2{cfg.gain_i[31]}}, cfg.gain_i};
        mul_b = {{2{integrator[31]}}, integrator};
      end
      MS_D: begin
        mul_a = {{2{cfg.gain_d[31]}}, cfg.gain_d};
        mul_b = {{2{derivative[31]}}, derivative};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round to nearest, ties up, then saturate
  assign rnd = prod_q + 64'sd32768;
  assign shf = rnd[63:16];
  always_comb begin
    if (shf > 48'sd2147483647) begin
      rnd_sat = 32'sh7fffffff;
    end else if (shf < -48'sd2147483648) begin
      rnd_sat = 32'sh80000000;
    end else begin
      rnd_sat = shf[31:0];
    end
  end

  assign lim = {3'b000, cfg.pitch_limit};
  assign sum35 = {sum[33], sum};
  assign lim35 = {4'b0000, cfg.pitch_limit};
  always_comb begin
    if (sum > lim) begin
      pitch = lim;
    end else if (sum < -lim) begin
      pitch = -lim;
    end else begin
      pitch = sum;
    end
  end
  // deviation of at least 7 LSB from the limited value
  assign held = (sum35 > lim35 + HoldEpsM1) || (sum35 < -lim35 - HoldEpsM1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= altitude_command;
      meas_q <= altitude_measured;
    end
    if (cmd.calc_err) begin
      if (diff > zw33) begin
        err <= zw33[31:0];
      end else if (diff < -zw33) begin
        err <= 32'(-zw33);
      end else begin
        err <= diff[31:0];
      end
    end
    if (cmd.calc_zone) begin
      in_zone <= (err34 > zone_lo) && (err34 < zone_hi);
      dsum    <= {err[31], err} + {last_error[31], last_error};
      ddif    <= {err[31], err} - {last_error[31], last_error};
    end
    if (cmd.mul_en) begin
      prod_q <= prod[63:0];
    end
    q <= rnd_sat;
    if (cmd.acc_load) begin
      acc <= q;
    end
    if (cmd.sum_load) begin
      sum <= {{2{q[31]}}, q};
    end else if (cmd.sum_add) begin
      sum <= sum + {{2{q[31]}}, q};
    end
    if (cmd.int_upd) begin
      prev_int <= integrator;
    end
    if (cmd.finish) begin
      pitch_command <= pitch[31:0];
      clamped       <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      last_error <= '0;
      derivative <= '0;
    end else begin
      if (cmd.load && restart) begin
        integrator <= '0;
        last_error <= '0;
        derivative <= '0;
      end
      if (cmd.int_upd) begin
        integrator <= in_zone ? sat_33({integrator[31], integrator} + {q[31], q}) : '0;
      end
      if (cmd.deriv_upd) begin
        derivative <= sat_33({acc[31], acc} + {q[31], q});
      end
      if (cmd.finish) begin
        last_error <= err;
        if (held) begin
          integrator <= prev_int;
        end
      end
    end
  end

endmodule

// ===== verif/pitch_loop_checker.sv =====
`timescale 1ns / 1ps

module pitch_loop_checker
  import ahpp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [DataW-1:0] altitude_command,
  input  logic signed [DataW-1:0] altitude_measured,
  input  logic                    restart,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [DataW-1:0] pitch_command,
  input  logic                    clamped,
  input  logic                    cfg_write,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [DataW-1:0]        cfg_data,
  output int                      mismatches,
  output int                      outstanding
);

  localparam longint MarginLsb = 655;
  localparam longint HoldLsb   = 7;
  localparam longint Max32     = 64'sd2147483647;
  localparam longint Min32     = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] pitch;
    logic               held;
  } pitch_out_t;

  pitch_out_t pitch_due[$];
  int fail_count = 0;

  // tuning copy
  logic signed [31:0] kp, ki, kd;
  logic        [16:0] half_per;
  logic signed [17:0] pole;
  logic        [30:0] dgain, plim, zone;

  // loop state, each holds a 32-bit value
  longint integ, prev_err, deriv;

  assign mismatches = fail_count;

  function automatic longint clip32(longint x);
    if (x > Max32) return Max32;
    if (x < Min32) return Min32;
    return x;
  endfunction

  // exact product, round half up, floor shift, saturate
  function automatic longint qmul(longint a, longint b);
    logic signed [79:0] prod;
    prod = a * b;
    prod = (prod + 80'sd32768) >>> 16;
    if (prod > 80'sd2147483647) return Max32;
    if (prod < -80'sd2147483648) return Min32;
    return longint'(prod);
  endfunction

  function automatic pitch_out_t advance_pitch_loop(longint cmd, longint meas, logic rs);
    pitch_out_t res;
    longint     err, zw, lim, saved_int, sum, pitch, dev;
    if (rs) begin
      integ    = 0;
      prev_err = 0;
      deriv    = 0;
    end
    zw  = zone;
    lim = plim;
    err = cmd - meas;
    if (err > zw) err = zw;
    if (err < -zw) err = -zw;

    saved_int = integ;
    if ((-zw + MarginLsb < err) && (err < zw - MarginLsb))
      integ = clip32(integ + qmul(half_per, err + prev_err));
    else
      integ = 0;

    deriv = clip32(qmul(pole, deriv) + qmul(dgain, err - prev_err));

    // unsaturated sum is what the limit test sees
    sum = qmul(kp, err) + qmul(ki, integ) + qmul(kd, deriv);
    pitch = sum;
    if (pitch > lim) pitch = lim;
    if (pitch < -lim) pitch = -lim;
    dev = sum - pitch;
    if (dev < 0) dev = -dev;
    res.held = (dev >= HoldLsb);
    if (res.held) integ = saved_int;
    prev_err = err;
    res.pitch = pitch[31:0];
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("ERROR %0t ns: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pitch_out_t want;
    if (rst) begin
      kp       = GainPRst;
      ki       = GainIRst;
      kd       = GainDRst;
      half_per = HalfPerRst;
      pole     = DerivPoleRst;
      dgain    = DerivGainRst;
      plim     = PitchLimRst;
      zone     = ZoneWidthRst;
      integ    = 0;
      prev_err = 0;
      deriv    = 0;
      pitch_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GAIN_P:      kp = cfg_data;
          CFG_GAIN_I:      ki = cfg_data;
          CFG_GAIN_D:      kd = cfg_data;
          CFG_HALF_PERIOD: half_per = cfg_data[16:0];
          CFG_DERIV_POLE:  pole = cfg_data[17:0];
          CFG_DERIV_GAIN:  dgain = cfg_data[30:0];
          CFG_PITCH_LIMIT: plim = cfg_data[30:0];
          CFG_ZONE_WIDTH:  zone = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pitch_due.push_back(advance_pitch_loop(altitude_command, altitude_measured, restart));
      if (out_valid && out_ready) begin
        if (pitch_due.size() == 0) begin
          flag_mismatch("result with nothing pending, pitch_command", pitch_command, 0);
        end else begin
          want = pitch_due.pop_front();
          if (pitch_command !== want.pitch)
            flag_mismatch("pitch_command", pitch_command, want.pitch);
          if (clamped !== want.held)
            flag_mismatch("clamped", clamped, want.held);
        end
      end
      outstanding <= pitch_due.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ahpp_pkg::*;

  typedef enum {
    TUNE_DEFAULT,
    TUNE_RANDOM,
    TUNE_MAX,
    TUNE_MIN,
    TUNE_WILD,
    TUNE_THIN_ZONE
  } tuning_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [DataW-1:0] altitude_command = '0;
  logic signed [DataW-1:0] altitude_measured = '0;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DataW-1:0] pitch_command;
  logic                    clamped;
  logic                    cfg_write = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [DataW-1:0]        cfg_data = '0;
  int                      mismatches;
  int                      outstanding;

  longint zone_now = ZoneWidthRst;
  bit     steady = 1'b0;

  altitude_hold_pitch_pid_core DUT (.*);
  pitch_loop_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] rand_signed(int unsigned mag);
    return 32'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // error offsets: mostly around the zone, some on the margin and zone edges, some wild
  function automatic longint pick_error(longint zw);
    longint span, base;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      span = zw + 2000;
      if (span > 64'sd1073741824) span = 64'sd1073741824;
      return longint'($urandom_range(0, 2 * span)) - span;
    end
    if (r < 85) begin
      base = $urandom_range(0, 1) ? zw - longint'(ZoneMargin) : zw;
      base = base + longint'($urandom_range(0, 6)) - 3;
      return $urandom_range(0, 1) ? base : -base;
    end
    return longint'($signed($urandom));
  endfunction

  task automatic send_item(logic [31:0] cmd, logic [31:0] meas, logic rs);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    altitude_command  <= cmd;
    altitude_measured <= meas;
    restart           <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_error(longint e, logic rs);
    send_item(32'(e), 32'd0, rs);
  endtask

  // stop sending and wait for every pending result plus the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_tuning(tuning_t mode);
    logic [31:0] v [8];
    case (mode)
      TUNE_DEFAULT: begin
        v[CFG_GAIN_P]      = GainPRst;
        v[CFG_GAIN_I]      = GainIRst;
        v[CFG_GAIN_D]      = GainDRst;
        v[CFG_HALF_PERIOD] = 32'(HalfPerRst);
        v[CFG_DERIV_POLE]  = 32'(DerivPoleRst);
        v[CFG_DERIV_GAIN]  = 32'(DerivGainRst);
        v[CFG_PITCH_LIMIT] = 32'(PitchLimRst);
        v[CFG_ZONE_WIDTH]  = 32'(ZoneWidthRst);
      end
      TUNE_MAX: begin
        v[CFG_GAIN_P]      = 32'h7FFF_FFFF;
        v[CFG_GAIN_I]      = 32'h7FFF_FFFF;
        v[CFG_GAIN_D]      = 32'h7FFF_FFFF;
        v[CFG_HALF_PERIOD] = 32'd65536;
        v[CFG_DERIV_POLE]  = 32'd65536;
        v[CFG_DERIV_GAIN]  = 32'h7FFF_FFFF;
        v[CFG_PITCH_LIMIT] = 32'h7FFF_FFFF;
        v[CFG_ZONE_WIDTH]  = 32'h7FFF_FFFF;
      end
      TUNE_MIN: begin
        v[CFG_GAIN_P]      = 32'h8000_0000;
        v[CFG_GAIN_I]      = 32'h8000_0000;
        v[CFG_GAIN_D]      = 32'h8000_0000;
        v[CFG_HALF_PERIOD] = 32'd0;
        v[CFG_DERIV_POLE]  = rand_signed(65536) | 32'hFFFF_0000; // from -1.0 up to just below 0
        v[CFG_DERIV_GAIN]  = 32'd0;
        v[CFG_PITCH_LIMIT] = 32'd0;
        v[CFG_ZONE_WIDTH]  = 32'd0;
      end
      TUNE_WILD: begin
        // full-width patterns, upper bits of narrow registers included
        v[CFG_GAIN_P]      = $urandom;
        v[CFG_GAIN_I]      = $urandom;
        v[CFG_GAIN_D]      = $urandom;
        v[CFG_HALF_PERIOD] = $urandom;
        v[CFG_DERIV_POLE]  = $urandom;
        v[CFG_DERIV_GAIN]  = $urandom;
        v[CFG_PITCH_LIMIT] = $urandom;
        v[CFG_ZONE_WIDTH]  = $urandom;
      end
      default: begin
        v[CFG_GAIN_P]      = rand_signed(1 << 18);
        v[CFG_GAIN_I]      = rand_signed(1 << 17);
        v[CFG_GAIN_D]      = rand_signed(1 << 16);
        v[CFG_HALF_PERIOD] = $urandom_range(0, 65536);
        v[CFG_DERIV_POLE]  = rand_signed(65536);
        v[CFG_DERIV_GAIN]  = $urandom_range(0, 1 << 20);
        v[CFG_PITCH_LIMIT] = $urandom_range(0, 1 << 19);
        if (mode == TUNE_THIN_ZONE)
          v[CFG_ZONE_WIDTH] = $urandom_range(600, 1400);
        else if ($urandom_range(0, 3) == 0)
          v[CFG_ZONE_WIDTH] = $urandom_range(0, 32'h7FFF_FFFF);
        else
          v[CFG_ZONE_WIDTH] = $urandom_range(0, 1 << 22);
      end
    endcase
    for (int i = 0; i < 8; i++)
      put_reg(cfg_idx_t'(i), v[i]);
    cfg_write <= 1'b0;
    zone_now = longint'(v[CFG_ZONE_WIDTH][30:0]);
  endtask

  // result side: random stall before each transfer, none in steady mode
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    tuning_t plan [10];
    longint  e;
    plan = '{TUNE_RANDOM, TUNE_MAX, TUNE_RANDOM, TUNE_MIN, TUNE_WILD,
             TUNE_THIN_ZONE, TUNE_RANDOM, TUNE_DEFAULT, TUNE_WILD, TUNE_RANDOM};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes and the zone edges at reset tuning
    send_error(0, 1'b1);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_error(zone_now - ZoneMargin, 1'b0);
    send_error(zone_now - ZoneMargin - 1, 1'b0);
    send_error(-(zone_now - ZoneMargin - 1), 1'b0);
    send_error(-(zone_now - ZoneMargin), 1'b0);
    send_error(zone_now, 1'b0);
    send_error(zone_now + 1, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_error(1, 1'b1);
    send_item(32'h8000_0064, 32'h8000_0000, 1'b0);
    drain();

    // unity P gain so the limit acts, including right after the integrator clears
    put_reg(CFG_GAIN_P, 32'd65536);
    cfg_write <= 1'b0;
    send_error(1000, 1'b0);
    send_error(5000, 1'b0);
    send_error(20000, 1'b0);
    send_error(30000, 1'b0);
    send_error(700000, 1'b0);
    send_error(-700000, 1'b0);
    send_error(30000, 1'b1);
    send_error(-22877, 1'b0);
    send_error(0, 1'b0);

    foreach (plan[p]) begin
      drain();
      load_tuning(plan[p]);
      steady = ($urandom_range(0, 3) == 0);
      repeat (48) begin
        e = pick_error(zone_now);
        altitude_measured_pick: begin
          logic [31:0] meas;
          meas = $urandom;
          send_item(meas + 32'(e), meas, $urandom_range(0, 19) == 0);
        end
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
